// ===== design/vspc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vspc_pkg: shared types and constants of the sampling period controller
// Field widths, register indexes and the microcode word format of the
// sequencer that runs one control update per item.
// ----------------------------------------------------------------------------
package vspc_pkg;

    // field and register widths
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int PHASOR_W         = 32;
    localparam int PERIOD_W         = 18;
    localparam int CFG_DATA_W       = 21;
    localparam int CFG_INDEX_W      = 3;
    localparam int SETPOINT_W       = 21;
    localparam int GAIN_W           = 16;
    localparam int OFFSET_W         = 21;
    localparam int ERR_W            = 32;
    localparam int PROD_W           = GAIN_W + ERR_W;
    localparam int GAIN_SHIFT       = 20;
    localparam int TERM_W           = PROD_W - GAIN_SHIFT;
    localparam int ACC_W            = 32;
    localparam int DIV_SHIFT        = 15;
    localparam int Q5_SHIFT         = 5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_NOW   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_PREV  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_OLDER = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_MAX = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_MIN = 3'd6;

    // microcode program
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_IDLE   = 4'd0;
    localparam pc_t PC_PREP   = 4'd1;
    localparam pc_t PC_DIV    = 4'd2;
    localparam pc_t PC_ERR    = 4'd3;
    localparam pc_t PC_MUL0   = 4'd4;
    localparam pc_t PC_MAC1   = 4'd5;
    localparam pc_t PC_MAC2   = 4'd6;
    localparam pc_t PC_ACC    = 4'd7;
    localparam pc_t PC_CLAMP  = 4'd8;
    localparam pc_t PC_PERIOD = 4'd9;
    localparam pc_t PC_FIXED  = 4'd10;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_PREP,
        OP_DIV,
        OP_ERR,
        OP_MUL0,
        OP_MAC1,
        OP_MAC2,
        OP_ACC,
        OP_CLAMP,
        OP_PERIOD,
        OP_FIXED
    } op_t;

    typedef enum logic [2:0] {
        J_NEXT,     // always to pc + 1
        J_WAIT_IN,  // hold until an item is taken
        J_IF_FIXED, // to target in fixed mode, else pc + 1
        J_DIV,      // hold until the last divide step
        J_OUT       // to target once the output register is free
    } jump_t;

    typedef struct packed {
        op_t   op;
        jump_t jump;
        pc_t   target;
    } ctrl_word_t;

    // control store
    function automatic ctrl_word_t ucode(input pc_t pc);
        ctrl_word_t cw;
        cw = '{op: OP_LOAD, jump: J_WAIT_IN, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:   cw = '{op: OP_LOAD,   jump: J_WAIT_IN,  target: PC_IDLE};
            PC_PREP:   cw = '{op: OP_PREP,   jump: J_IF_FIXED, target: PC_FIXED};
            PC_DIV:    cw = '{op: OP_DIV,    jump: J_DIV,      target: PC_IDLE};
            PC_ERR:    cw = '{op: OP_ERR,    jump: J_NEXT,     target: PC_IDLE};
            PC_MUL0:   cw = '{op: OP_MUL0,   jump: J_NEXT,     target: PC_IDLE};
            PC_MAC1:   cw = '{op: OP_MAC1,   jump: J_NEXT,     target: PC_IDLE};
            PC_MAC2:   cw = '{op: OP_MAC2,   jump: J_NEXT,     target: PC_IDLE};
            PC_ACC:    cw = '{op: OP_ACC,    jump: J_NEXT,     target: PC_IDLE};
            PC_CLAMP:  cw = '{op: OP_CLAMP,  jump: J_NEXT,     target: PC_IDLE};
            PC_PERIOD: cw = '{op: OP_PERIOD, jump: J_OUT,      target: PC_IDLE};
            PC_FIXED:  cw = '{op: OP_FIXED,  jump: J_OUT,      target: PC_IDLE};
            default:   cw = '{op: OP_LOAD,   jump: J_WAIT_IN,  target: PC_IDLE};
        endcase
        return cw;
    endfunction

endpackage : vspc_pkg
`default_nettype wire

// ===== design/variable_sampling_period_control.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// variable_sampling_period_control: sampling period tracking controller
// Takes one fundamental phasor per item and returns the timer period, in
// whole ticks, for the next sampling interval.
// ----------------------------------------------------------------------------
// Usage
//   Input channel  : in_valid / in_stall carrying phasor_imag, phasor_real.
//   Output channel : out_valid / out_stall carrying period_ticks.
//   Config port    : cfg_we, cfg_index, cfg_data; write only while idle.
//   A microcoded sequencer runs one item at a time; in_stall is low only
//   while the sequencer sits at its idle step.
//   Tracking mode: once the item is taken, the sequencer runs the prepare
//   step, the restoring divider (one quotient bit a cycle), then the error,
//   multiply, accumulate, clamp and period steps. Fixed mode: the prepare
//   step, then the fixed period step. The next item is taken only once the
//   sequencer is back at its idle step, in either mode.
//   The result sits in an output register, so a stalled receiver holds only
//   the final step; the next item is taken and worked on meanwhile.
//   Reset: fixed mode on, all other configuration registers and the error history and
//   offset accumulator cleared, no result pending.
// ----------------------------------------------------------------------------
module variable_sampling_period_control #(
    parameter int SAMPLE_WIDTH = vspc_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [vspc_pkg::PHASOR_W-1:0]   phasor_imag,
    input  wire logic signed [vspc_pkg::PHASOR_W-1:0]   phasor_real,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [vspc_pkg::PERIOD_W-1:0]        period_ticks,
    input  wire logic                                   cfg_we,
    input  wire logic [vspc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [vspc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import vspc_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int DVS_W = SW - DIV_SHIFT;
    localparam int CNT_W = $clog2(SW);

    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

    // configuration registers
    logic                        fixed_mode_reg;
    logic [SETPOINT_W-1:0]       setpoint_reg;
    logic signed [GAIN_W-1:0]    gain_now_reg;
    logic signed [GAIN_W-1:0]    gain_prev_reg;
    logic signed [GAIN_W-1:0]    gain_older_reg;
    logic signed [OFFSET_W-1:0]  offset_max_reg;
    logic signed [OFFSET_W-1:0]  offset_min_reg;

    // controller state
    logic signed [ERR_W-1:0]     err_newest_reg;
    logic signed [ERR_W-1:0]     err_previous_reg;
    logic signed [ERR_W-1:0]     err_oldest_reg;
    logic signed [OFFSET_W-1:0]  offset_reg;

    // sequencer and working registers
    pc_t                         pc_reg;
    pc_t                         pc_next;
    ctrl_word_t                  cw;
    logic [SW-1:0]               imag_reg;
    logic [SW-1:0]               real_reg;
    logic                        imag_neg_reg;
    logic                        imag_zero_reg;
    logic [DVS_W-1:0]            dvs_reg;
    logic [SW:0]                 rem_reg;
    logic [SW-1:0]               quo_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [PERIOD_W-1:0]  period_reg;

    logic                        in_take;
    logic                        out_free;
    logic                        cnt_last;
    logic [SW-1:0]               imag_mag;
    logic [SW-1:0]               real_mag;
    logic [SW:0]                 rem_shift;
    logic                        rem_ge;
    logic signed [ERR_W:0]       q_ext;
    logic signed [ERR_W:0]       q_neg;
    logic signed [ERR_W-1:0]     err_calc;
    logic signed [GAIN_W-1:0]    mul_a;
    logic signed [ERR_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]    mul_out;
    logic signed [TERM_W-1:0]    term;
    logic signed [ACC_W-1:0]     acc_sum;
    logic signed [ACC_W-1:0]     max_ext;
    logic signed [ACC_W-1:0]     min_ext;
    logic signed [OFFSET_W+1:0]  period_sum;

    assign cw        = ucode(pc_reg);
    assign in_stall  = (pc_reg != PC_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cnt_last  = (cnt_reg == CNT_W'(SW - 1));
    assign out_valid    = out_valid_reg;
    assign period_ticks = period_reg;

    // result register: set at the output steps, held while stalled
    assign out_valid_next = (cw.op == OP_PERIOD) || (cw.op == OP_FIXED)
                            || (out_valid_reg && out_stall);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_mode_reg <= 1'b1;
            setpoint_reg   <= '0;
            gain_now_reg   <= '0;
            gain_prev_reg  <= '0;
            gain_older_reg <= '0;
            offset_max_reg <= '0;
            offset_min_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIXED_MODE: fixed_mode_reg <= cfg_data[0];
                CFG_SETPOINT:   setpoint_reg   <= cfg_data[SETPOINT_W-1:0];
                CFG_GAIN_NOW:   gain_now_reg   <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_PREV:  gain_prev_reg  <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_OLDER: gain_older_reg <= cfg_data[GAIN_W-1:0];
                CFG_OFFSET_MAX: offset_max_reg <= cfg_data[OFFSET_W-1:0];
                CFG_OFFSET_MIN: offset_min_reg <= cfg_data[OFFSET_W-1:0];
                default:        ;
            endcase
        end
    end

    // next step of the program
    always_comb
    begin
        pc_next = pc_reg + pc_t'(1);
        unique case (cw.jump)
            J_NEXT:     pc_next = pc_reg + pc_t'(1);
            J_WAIT_IN:  pc_next = in_take ? pc_reg + pc_t'(1) : pc_reg;
            J_IF_FIXED: pc_next = fixed_mode_reg ? cw.target : pc_reg + pc_t'(1);
            J_DIV:      pc_next = cnt_last ? pc_reg + pc_t'(1) : pc_reg;
            J_OUT:      pc_next = out_free ? cw.target : pc_reg;
            default:    pc_next = PC_IDLE;
        endcase
    end

    // magnitudes of the sampled phasor
    assign imag_mag = imag_reg[SW-1] ? (~imag_reg + SW'(1)) : imag_reg;
    assign real_mag = real_reg[SW-1] ? (~real_reg + SW'(1)) : real_reg;

    // restoring divide step
    assign rem_shift = {rem_reg[SW-1:0], quo_reg[SW-1]};
    assign rem_ge    = (rem_shift >= (SW+1)'(dvs_reg));

    // phase error with saturation
    assign q_ext = signed'({{(ERR_W+1-SW){1'b0}}, quo_reg});
    assign q_neg = -q_ext;
    always_comb
    begin
        priority if (dvs_reg == '0)
            err_calc = imag_neg_reg ? ERR_MAX : (imag_zero_reg ? '0 : ERR_MIN);
        else if (imag_neg_reg)
            err_calc = (q_ext > signed'({1'b0, ERR_MAX})) ? ERR_MAX : q_ext[ERR_W-1:0];
        else
            err_calc = q_neg[ERR_W-1:0];
    end

    // shared gain multiplier
    always_comb
    begin
        unique case (cw.op)
            OP_MAC1:
            begin
                mul_a = gain_prev_reg;
                mul_b = err_previous_reg;
            end
            OP_MAC2:
            begin
                mul_a = gain_older_reg;
                mul_b = err_oldest_reg;
            end
            default:
            begin
                mul_a = gain_now_reg;
                mul_b = err_newest_reg;
            end
        endcase
    end
    assign mul_out = mul_a * mul_b;
    assign term    = prod_reg[PROD_W-1:GAIN_SHIFT];
    assign acc_sum = acc_reg + ACC_W'(term);

    assign max_ext    = ACC_W'(offset_max_reg);
    assign min_ext    = ACC_W'(offset_min_reg);
    assign period_sum = (OFFSET_W+2)'(offset_reg) + signed'({2'b00, setpoint_reg});

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= PC_IDLE;
            out_valid_reg    <= 1'b0;
            err_newest_reg   <= '0;
            err_previous_reg <= '0;
            err_oldest_reg   <= '0;
            offset_reg       <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            unique case (cw.op)
                OP_LOAD:
                begin
                    if (in_take)
                    begin
                        imag_reg <= phasor_imag[SW-1:0];
                        real_reg <= phasor_real[SW-1:0];
                    end
                end
                OP_PREP:
                begin
                    imag_neg_reg  <= imag_reg[SW-1];
                    imag_zero_reg <= (imag_reg == '0);
                    dvs_reg       <= real_mag[SW-1:DIV_SHIFT];
                    quo_reg       <= imag_mag;
                    rem_reg       <= '0;
                    cnt_reg       <= '0;
                end
                OP_DIV:
                begin
                    rem_reg <= rem_ge ? (rem_shift - (SW+1)'(dvs_reg)) : rem_shift;
                    quo_reg <= {quo_reg[SW-2:0], rem_ge};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                OP_ERR:
                begin
                    err_oldest_reg   <= err_previous_reg;
                    err_previous_reg <= err_newest_reg;
                    err_newest_reg   <= err_calc;
                    acc_reg          <= ACC_W'(offset_reg);
                end
                OP_MUL0:
                begin
                    prod_reg <= mul_out;
                end
                OP_MAC1, OP_MAC2:
                begin
                    prod_reg <= mul_out;
                    acc_reg  <= acc_sum;
                end
                OP_ACC:
                begin
                    acc_reg <= acc_sum;
                end
                OP_CLAMP:
                begin
                    priority if (acc_reg > max_ext)
                    begin
                        offset_reg     <= offset_max_reg;
                        err_newest_reg <= err_previous_reg;
                    end
                    else if (acc_reg < min_ext)
                    begin
                        offset_reg     <= offset_min_reg;
                        err_newest_reg <= err_previous_reg;
                    end
                    else
                        offset_reg <= acc_reg[OFFSET_W-1:0];
                end
                OP_PERIOD:
                begin
                    if (out_free)
                        period_reg <= period_sum[OFFSET_W+1:Q5_SHIFT];
                end
                OP_FIXED:
                begin
                    if (out_free)
                        period_reg <= signed'({2'b00, setpoint_reg[SETPOINT_W-1:Q5_SHIFT]});
                end
                default: ;
            endcase
        end
    end

endmodule : variable_sampling_period_control
`default_nettype wire

// ===== design/vspc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vspc_checker: port-level checks of the sampling period controller
// Watches the handshakes of the top level and the one-item-at-a-time flow.
// ----------------------------------------------------------------------------
module vspc_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_stall,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic signed [vspc_pkg::PERIOD_W-1:0] period_ticks
);
    import vspc_pkg::*;

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(period_ticks))
        else $error("result changed while stalled");

    // a taken item keeps the block busy on the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an item was taken");

    // a new result only comes out of a busy sequencer
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in progress");

endmodule : vspc_checker

bind variable_sampling_period_control vspc_checker u_vspc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .period_ticks (period_ticks)
);
`default_nettype wire

// ===== test/period_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// period_checker: scoreboard for the sampling period controller
// Watches the configuration port and both item channels, keeps its own copy
// of the registers, error history and offset accumulator, works out the
// period due for every phasor taken and compares it with what comes out.
// ----------------------------------------------------------------------------
module period_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [vspc_pkg::PHASOR_W-1:0] phasor_imag,
    input  logic signed [vspc_pkg::PHASOR_W-1:0] phasor_real,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [vspc_pkg::PERIOD_W-1:0] period_ticks,
    input  logic                                 cfg_we,
    input  logic [vspc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vspc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   bad_periods,
    output int                                   periods_checked,
    output int                                   periods_pending,
    output int                                   clamp_events
);
    import vspc_pkg::*;

    localparam logic signed [ERR_W-1:0] ERR_POS_LIMIT = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_NEG_LIMIT = {1'b1, {(ERR_W-1){1'b0}}};

    // register copies
    logic                        fixed_q;
    logic        [SETPOINT_W-1:0] setpoint_q;
    logic signed [GAIN_W-1:0]    gain_now_q;
    logic signed [GAIN_W-1:0]    gain_prev_q;
    logic signed [GAIN_W-1:0]    gain_older_q;
    logic signed [OFFSET_W-1:0]  clamp_hi;
    logic signed [OFFSET_W-1:0]  clamp_lo;

    // loop state
    logic signed [ERR_W-1:0]     err_new;
    logic signed [ERR_W-1:0]     err_prev;
    logic signed [ERR_W-1:0]     err_old;
    logic signed [OFFSET_W-1:0]  offset_q;

    logic signed [PERIOD_W-1:0]  periods_due [$];
    logic signed [PERIOD_W-1:0]  period_exp;

    // phase error: -imag / (|real| >> 15), saturated; zero divisor: limit or 0
    function automatic logic signed [ERR_W-1:0] phase_error(
        input logic signed [PHASOR_W-1:0] im,
        input logic signed [PHASOR_W-1:0] re
    );
        longint mag;
        longint div;
        longint quo;
        mag = longint'(re);
        if (mag < 0)
            mag = -mag;
        div = mag >>> DIV_SHIFT;
        if (div == 0)
        begin
            if (im > 0)
                return ERR_NEG_LIMIT;
            else if (im < 0)
                return ERR_POS_LIMIT;
            else
                return '0;
        end
        quo = -(longint'(im) / div);
        if (quo > longint'(ERR_POS_LIMIT))
            quo = longint'(ERR_POS_LIMIT);
        if (quo < longint'(ERR_NEG_LIMIT))
            quo = longint'(ERR_NEG_LIMIT);
        return quo[ERR_W-1:0];
    endfunction

    // one control update; moves the history and accumulator along
    function automatic logic signed [PERIOD_W-1:0] predict_period(
        input logic signed [PHASOR_W-1:0] im,
        input logic signed [PHASOR_W-1:0] re
    );
        longint sp;
        longint acc;
        longint gn;
        longint gp;
        longint go;
        longint en;
        longint ep;
        longint eo;
        sp = longint'(setpoint_q);
        if (fixed_q)
            return PERIOD_W'(sp >>> Q5_SHIFT);
        err_old  = err_prev;
        err_prev = err_new;
        err_new  = phase_error(im, re);
        gn = longint'(gain_now_q);
        gp = longint'(gain_prev_q);
        go = longint'(gain_older_q);
        en = longint'(err_new);
        ep = longint'(err_prev);
        eo = longint'(err_old);
        acc = longint'(offset_q);
        acc = acc + ((gn * en) >>> GAIN_SHIFT) + ((gp * ep) >>> GAIN_SHIFT)
                  + ((go * eo) >>> GAIN_SHIFT);
        // upper bound checked first, so it wins when the bounds cross
        if (acc > longint'(clamp_hi))
        begin
            acc = longint'(clamp_hi);
            err_new = err_prev;
            clamp_events++;
        end
        else if (acc < longint'(clamp_lo))
        begin
            acc = longint'(clamp_lo);
            err_new = err_prev;
            clamp_events++;
        end
        offset_q = acc[OFFSET_W-1:0];
        return PERIOD_W'((acc + sp) >>> Q5_SHIFT);
    endfunction

    initial
    begin
        bad_periods     = 0;
        periods_checked = 0;
        periods_pending = 0;
        clamp_events    = 0;
    end

    // config writes, then items in, then items out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_q      = 1'b1;
            setpoint_q   = '0;
            gain_now_q   = '0;
            gain_prev_q  = '0;
            gain_older_q = '0;
            clamp_hi     = '0;
            clamp_lo     = '0;
            err_new      = '0;
            err_prev     = '0;
            err_old      = '0;
            offset_q     = '0;
            periods_due.delete();
            periods_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIXED_MODE: fixed_q      = cfg_data[0];
                    CFG_SETPOINT:   setpoint_q   = cfg_data[SETPOINT_W-1:0];
                    CFG_GAIN_NOW:   gain_now_q   = cfg_data[GAIN_W-1:0];
                    CFG_GAIN_PREV:  gain_prev_q  = cfg_data[GAIN_W-1:0];
                    CFG_GAIN_OLDER: gain_older_q = cfg_data[GAIN_W-1:0];
                    CFG_OFFSET_MAX: clamp_hi     = cfg_data[OFFSET_W-1:0];
                    CFG_OFFSET_MIN: clamp_lo     = cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                periods_due.push_back(predict_period(phasor_imag, phasor_real));
            if (out_valid && !out_stall)
            begin
                if (periods_due.size() == 0)
                begin
                    bad_periods++;
                    $display("%0t: period %0d arrived with none due", $time, period_ticks);
                end
                else
                begin
                    period_exp = periods_due.pop_front();
                    periods_checked++;
                    if (period_ticks !== period_exp)
                    begin
                        bad_periods++;
                        $display("%0t: period_ticks expected %0d, got %0d",
                                 $time, period_exp, period_ticks);
                    end
                end
            end
            periods_pending = periods_due.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for variable_sampling_period_control
// Drives phasors and register settings, stalls the result side at random and
// once for a long stretch, and leaves prediction and comparison to the
// period checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import vspc_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int INVERTED_PHASE  = 3;
    localparam int PRESSURE_PHASE  = 2;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 60;
    localparam int QUIET_LIMIT     = 3000;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [PHASOR_W-1:0]  phasor_imag;
    logic signed [PHASOR_W-1:0]  phasor_real;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [PERIOD_W-1:0]  period_ticks;
    logic                        cfg_we;
    logic [CFG_INDEX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    int bad_periods;
    int periods_checked;
    int periods_pending;
    int clamp_events;

    logic idling;
    int   hold_len;
    int   phasors_sent;
    int   settings_used;
    int   quiet_cycles;

    variable_sampling_period_control u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .phasor_imag  (phasor_imag),
        .phasor_real  (phasor_real),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .period_ticks (period_ticks),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    period_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .phasor_imag     (phasor_imag),
        .phasor_real     (phasor_real),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .period_ticks    (period_ticks),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .bad_periods     (bad_periods),
        .periods_checked (periods_checked),
        .periods_pending (periods_pending),
        .clamp_events    (clamp_events)
    );

    always #5 clk = ~clk;

    // watchdog: too long with nothing moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result side: random stall bursts, or one long hold on request
    initial
    begin : result_side
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                n = hold_len;
                hold_len = 0;
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // offer one phasor and hold it until taken; gaps chain so they can end
    // anywhere within a tracking update
    task automatic send(input logic [PHASOR_W-1:0] im, input logic [PHASOR_W-1:0] re);
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            do
                repeat ($urandom_range(1, 6)) @(negedge clk);
            while ($urandom_range(0, 2) == 0);
        end
        in_valid    = 1'b1;
        phasor_imag = im;
        phasor_real = re;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        phasors_sent++;
    endtask

    // drop valid, wait for every period due, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (periods_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                          kind;
        logic signed [PHASOR_W-1:0]  im;
        logic signed [PHASOR_W-1:0]  re;
        logic signed [OFFSET_W-1:0]  hi;
        logic signed [OFFSET_W-1:0]  lo;
        logic signed [OFFSET_W-1:0]  swap;
        logic        [GAIN_W-1:0]    g;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        phasor_imag   = '0;
        phasor_real   = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        idling        = 1'b1;
        hold_len      = 0;
        phasors_sent  = 0;
        settings_used = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // fixed mode straight out of reset, setpoint zero
        send(32'h7FFF_FFFF, 32'h8000_0000);
        send(32'h0, 32'h0);
        settle();
        write_reg(CFG_SETPOINT, 21'h1F_FFFF);
        settings_used += 2;
        send(32'h8000_0000, 32'h7FFF_FFFF);
        settle();

        // tracking, gentle gains, full clamp range
        write_reg(CFG_FIXED_MODE, 21'd0);
        write_reg(CFG_SETPOINT, 21'd640000);
        write_reg(CFG_GAIN_NOW, 21'd64);
        write_reg(CFG_GAIN_PREV, CFG_DATA_W'(-32));
        write_reg(CFG_GAIN_OLDER, 21'd16);
        write_reg(CFG_OFFSET_MAX, 21'h0F_FFFF);
        write_reg(CFG_OFFSET_MIN, 21'h10_0000);
        settings_used++;
        send(32'd0, 32'd0);                     // zero divisor, zero imag
        send(32'd1, 32'd32767);                 // zero divisor, positive imag
        send(-1, -32768);                       // smallest non-zero divisor
        send(-5, 32'd1);                        // zero divisor, negative imag
        send(32'h8000_0000, 32'd32768);         // quotient overflows, saturates
        send(32'h7FFF_FFFF, 32'h8000_0000);     // largest divisor
        send(32'h8000_0000, 32'h8000_0000);
        send(-7, 3 << 15);                      // truncation toward zero
        send(7, -(3 << 15));
        send(32'd1000000, 32'h7FFF_FFFF);
        settle();

        // extreme gains drive both clamps, negative period at setpoint zero
        write_reg(CFG_SETPOINT, 21'd0);
        write_reg(CFG_GAIN_NOW, 21'h1F_8000);
        write_reg(CFG_GAIN_PREV, 21'h00_7FFF);
        write_reg(CFG_GAIN_OLDER, 21'h1F_8000);
        settings_used++;
        send(32'd1, 32'd0);
        send(-1, 32'd0);
        send(-1, 32'd0);
        send(32'd1, 32'd0);
        settle();

        // crossed clamp bounds; the spare index must change nothing
        write_reg(CFG_SETPOINT, 21'd32000);
        write_reg(CFG_GAIN_NOW, 21'd100);
        write_reg(CFG_GAIN_PREV, 21'd200);
        write_reg(CFG_GAIN_OLDER, 21'd300);
        write_reg(CFG_OFFSET_MAX, CFG_DATA_W'(-500));
        write_reg(CFG_OFFSET_MIN, 21'd500);
        write_reg(CFG_SPARE, 21'h1F_FFFF);
        settings_used++;
        send(32'd12345, 32'h0040_0000);
        send(-12345, 32'h0040_0000);
        send(32'h7FFF_0000, -32'h0001_0000);
        settle();

        // random phases, each under fresh register values
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                idling = 1'b0;
            write_reg(CFG_FIXED_MODE, (p == 0) ? 21'd1 : 21'd0);
            write_reg(CFG_SETPOINT, (p == PHASES - 1) ? 21'h1F_FFFF
                                    : CFG_DATA_W'($urandom_range(0, 2097151)));
            for (int j = 0; j < 3; j++)
            begin
                case ($urandom_range(0, 2))
                    0:       g = GAIN_W'($urandom());
                    1:       g = GAIN_W'($urandom_range(0, 4095) - 2048);
                    default: g = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                endcase
                write_reg(CFG_INDEX_W'(CFG_GAIN_NOW + j), {{(CFG_DATA_W-GAIN_W){g[GAIN_W-1]}}, g});
            end
            if (p == PHASES - 1 || $urandom_range(0, 1) == 0)
            begin
                hi = 21'h0F_FFFF;
                lo = 21'h10_0000;
            end
            else
            begin
                hi = OFFSET_W'($urandom());
                lo = OFFSET_W'($urandom());
                if (lo > hi)
                begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
            end
            if (p == INVERTED_PHASE && lo <= hi)
            begin
                swap = lo;
                lo   = OFFSET_W'(hi + 1);
                hi   = OFFSET_W'(swap - 1);
            end
            write_reg(CFG_OFFSET_MAX, hi);
            write_reg(CFG_OFFSET_MIN, lo);
            settings_used++;

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0:
                    begin
                        // divisor rounds to zero
                        re = $urandom_range(0, 32767);
                        if ($urandom_range(0, 1))
                            re = -re;
                        im = $urandom_range(0, 3) == 0 ? 32'sd0 : $urandom();
                    end
                    1:
                    begin
                        im = '0;
                        re = $urandom();
                    end
                    2, 3:
                    begin
                        im = $urandom();
                        re = $urandom();
                    end
                    4:
                    begin
                        // unit divisor, most negative imag
                        im = 32'h8000_0000;
                        re = $urandom_range(32768, 65535);
                        if ($urandom_range(0, 1))
                            re = -re;
                    end
                    default:
                    begin
                        // a locked-on phasor: large real part, modest phase
                        re = $urandom_range(32'h7FFF_FFFF, 32'h0010_0000);
                        if ($urandom_range(0, 1))
                            re = -re;
                        im = $signed($urandom()) >>> $urandom_range(7, 28);
                    end
                endcase
                send(im, re);
                if (p == PRESSURE_PHASE && k == 20)
                    hold_len = HOLD_CYCLES;
            end
            settle();
        end

        $display("covered %0d phasors under %0d register settings: %0d periods compared,",
                 phasors_sent, settings_used, periods_checked);
        $display("  %0d offset clamp events, one long result hold", clamp_events);
        if (bad_periods == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
